// File: sv/tisp_pkg.sv
// ----------------------------------------------------------------------------
// tisp_pkg
// Types and constants for the tag item stream parser.
// ----------------------------------------------------------------------------
package tisp_pkg;

    typedef enum logic [1:0] {
        PH_HALT = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DLFC = 3'd0,
        KIND_ROBM = 3'd1,
        KIND_FAC  = 3'd2,
        KIND_SDC  = 3'd3,
        KIND_STR0 = 3'd4
    } tag_kind_t;

    localparam logic [31:0] NAME_DLFC = 32'h646C_6663;
    localparam logic [31:0] NAME_ROBM = 32'h726F_626D;
    localparam logic [31:0] NAME_FAC  = 32'h6661_635F;
    localparam logic [31:0] NAME_SDC  = 32'h7364_635F;
    localparam logic [23:0] NAME_STR  = 24'h73_7472;
    localparam logic [7:0]  CHAR_0    = 8'h30;
    localparam logic [7:0]  CHAR_3    = 8'h33;

    localparam logic [31:0] DLFC_LEN  = 32'd32;
    localparam logic [31:0] ROBM_LEN  = 32'd8;

    localparam int unsigned HEADER_BITS = 64;
    localparam logic [5:0]  HDR_LAST    = 6'd63;

    localparam int unsigned TOTAL_BITS_W = 19;

endpackage

// File: sv/tag_item_stream_parser.sv
// ----------------------------------------------------------------------------
// tag_item_stream_parser
// Bit-serial TAG payload parser: header decode, tag classification and
// per-bit data output with empty and malformed markers.
// ----------------------------------------------------------------------------
// One payload bit per input transfer, one transfer per cycle sustained. Each
// transfer updates the parser state and produces at most one result, held in
// an output register; s_tready stays high while that register is empty or
// being drained, so the rate is set only by m_tready.
module tag_item_stream_parser #(
    parameter int PAYLOAD_COUNT_WIDTH = 19
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [0] payload_bit, [19:1] payload_total_bits
    input  logic        s_tuser,   // [0] payload_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] data_bit
    output logic [4:0]  m_tuser,   // [2:0] tag_kind, [3] empty_tag, [4] malformed
    output logic        m_tlast
);

    localparam int CW = PAYLOAD_COUNT_WIDTH;

    tisp_pkg::phase_t phase_reg, phase_next;
    logic [5:0]       hcnt_reg, hcnt_next;
    logic [31:0]      name_reg, name_next;
    logic [31:0]      len_reg, len_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [31:0]      dleft_reg, dleft_next;
    logic [2:0]       kind_reg, kind_next;
    logic             known_reg, known_next;

    logic             res_valid;
    logic [2:0]       res_kind;
    logic             res_bit;
    logic             res_last;
    logic             res_empty;
    logic             res_bad;

    logic             m_tvalid_reg;
    logic [2:0]       kind_out_reg;
    logic             bit_out_reg;
    logic             last_out_reg;
    logic             empty_out_reg;
    logic             bad_out_reg;

    logic             s_accept;
    logic             in_bit;
    logic [tisp_pkg::TOTAL_BITS_W-1:0] in_total;

    assign in_bit   = s_tdata[0];
    assign in_total = s_tdata[tisp_pkg::TOTAL_BITS_W:1];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        name_next  = name_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        dleft_next = dleft_reg;
        kind_next  = kind_reg;
        known_next = known_reg;
        res_valid  = 1'b0;
        res_kind   = 3'd0;
        res_bit    = 1'b0;
        res_last   = 1'b0;
        res_empty  = 1'b0;
        res_bad    = 1'b0;

        if (s_tuser) begin
            rem_next   = CW'(in_total);
            dleft_next = '0;
            kind_next  = 3'd0;
            known_next = 1'b0;
            phase_next = (rem_next >= CW'(tisp_pkg::HEADER_BITS)) ? tisp_pkg::PH_HEAD
                                                                  : tisp_pkg::PH_HALT;
            hcnt_next  = '0;
            name_next  = '0;
            len_next   = '0;
        end

        case (phase_next)
            tisp_pkg::PH_HEAD: begin
                if (!hcnt_next[5]) begin
                    name_next = {name_next[30:0], in_bit};
                end else begin
                    len_next = {len_next[30:0], in_bit};
                end
                rem_next = rem_next - CW'(1);
                if (hcnt_next != tisp_pkg::HDR_LAST) begin
                    hcnt_next = hcnt_next + 6'd1;
                end else begin
                    hcnt_next = '0;
                    if (len_next > 32'(rem_next)) begin
                        phase_next = tisp_pkg::PH_HALT;
                        res_valid  = 1'b1;
                        res_bad    = 1'b1;
                    end else begin
                        known_next = 1'b1;
                        if (name_next == tisp_pkg::NAME_DLFC &&
                            len_next == tisp_pkg::DLFC_LEN) begin
                            kind_next = tisp_pkg::KIND_DLFC;
                        end else if (name_next == tisp_pkg::NAME_ROBM &&
                                     len_next == tisp_pkg::ROBM_LEN) begin
                            kind_next = tisp_pkg::KIND_ROBM;
                        end else if (name_next == tisp_pkg::NAME_FAC) begin
                            kind_next = tisp_pkg::KIND_FAC;
                        end else if (name_next == tisp_pkg::NAME_SDC) begin
                            kind_next = tisp_pkg::KIND_SDC;
                        end else if (name_next[31:8] == tisp_pkg::NAME_STR &&
                                     name_next[7:0] >= tisp_pkg::CHAR_0 &&
                                     name_next[7:0] <= tisp_pkg::CHAR_3) begin
                            kind_next = tisp_pkg::KIND_STR0 + {1'b0, name_next[1:0]};
                        end else begin
                            kind_next  = 3'd0;
                            known_next = 1'b0;
                        end
                        dleft_next = len_next;
                        if (len_next == 32'd0) begin
                            phase_next = (rem_next >= CW'(tisp_pkg::HEADER_BITS))
                                         ? tisp_pkg::PH_HEAD : tisp_pkg::PH_HALT;
                            name_next  = '0;
                            len_next   = '0;
                            res_valid  = known_next;
                            res_kind   = kind_next;
                            res_last   = 1'b1;
                            res_empty  = 1'b1;
                        end else begin
                            phase_next = tisp_pkg::PH_DATA;
                        end
                    end
                end
            end
            tisp_pkg::PH_DATA: begin
                rem_next   = rem_next - CW'(1);
                dleft_next = dleft_next - 32'd1;
                res_last   = (dleft_next == 32'd0);
                if (res_last) begin
                    phase_next = (rem_next >= CW'(tisp_pkg::HEADER_BITS)) ? tisp_pkg::PH_HEAD
                                                                          : tisp_pkg::PH_HALT;
                    hcnt_next  = '0;
                    name_next  = '0;
                    len_next   = '0;
                end
                res_valid = known_next;
                res_kind  = kind_next;
                res_bit   = in_bit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tisp_pkg::PH_HALT;
            hcnt_reg  <= '0;
            name_reg  <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            dleft_reg <= '0;
            kind_reg  <= '0;
            known_reg <= 1'b0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            name_reg  <= name_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            dleft_reg <= dleft_next;
            kind_reg  <= kind_next;
            known_reg <= known_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= res_valid;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            kind_out_reg  <= res_kind;
            bit_out_reg   <= res_bit;
            last_out_reg  <= res_last;
            empty_out_reg <= res_empty;
            bad_out_reg   <= res_bad;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, bit_out_reg};
    assign m_tuser  = {bad_out_reg, empty_out_reg, kind_out_reg};
    assign m_tlast  = last_out_reg;

endmodule

// File: sim/tb_tag_item_stream_parser.sv
// ----------------------------------------------------------------------------
// tb_tag_item_stream_parser
// Self-checking bench for the bit-serial TAG payload parser. Payload bits are
// streamed in as single-bit transfers. Each accepted bit is run through a
// local model of the parser, and the results it predicts are compared with
// every result transfer on the output side. Stimulus is a set of directed
// payloads, followed by random well-formed payloads with some truncated,
// overlong, restarted and noise cases. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_tag_item_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1500;

    typedef struct {
        logic        pbit;
        logic        start;
        logic [18:0] total;
    } payload_xfer_t;

    typedef struct {
        logic [2:0] kind;
        logic       dbit;
        logic       last;
        logic       empty;
        logic       bad;
    } tag_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    payload_xfer_t pending_bits[$];
    tag_result_t   expected_tags[$];
    bit            frame_bits[$];

    int cycle_cnt   = 0;
    int err_cnt     = 0;

    // parser model state
    tisp_pkg::phase_t ph   = tisp_pkg::PH_HALT;
    logic [5:0]  hdr_cnt   = '0;
    logic [31:0] name_sr   = '0;
    logic [31:0] len_sr    = '0;
    logic [18:0] bits_left = '0;
    logic [31:0] data_left = '0;
    logic [2:0]  cur_kind  = '0;
    logic        cur_known = 1'b0;

    tag_item_stream_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    task automatic push_expect(input logic [2:0] kind, input logic dbit, input logic last,
                               input logic empty, input logic bad);
        tag_result_t r;
        r.kind  = kind;
        r.dbit  = dbit;
        r.last  = last;
        r.empty = empty;
        r.bad   = bad;
        expected_tags.insert(expected_tags.size(), r);
    endtask

    task automatic start_tag();
        ph      = (bits_left >= tisp_pkg::HEADER_BITS) ? tisp_pkg::PH_HEAD : tisp_pkg::PH_HALT;
        hdr_cnt = '0;
        name_sr = '0;
        len_sr  = '0;
    endtask

    task automatic classify_tag();
        cur_known = 1'b1;
        if (name_sr == tisp_pkg::NAME_DLFC && len_sr == tisp_pkg::DLFC_LEN) begin
            cur_kind = tisp_pkg::KIND_DLFC;
        end else if (name_sr == tisp_pkg::NAME_ROBM && len_sr == tisp_pkg::ROBM_LEN) begin
            cur_kind = tisp_pkg::KIND_ROBM;
        end else if (name_sr == tisp_pkg::NAME_FAC) begin
            cur_kind = tisp_pkg::KIND_FAC;
        end else if (name_sr == tisp_pkg::NAME_SDC) begin
            cur_kind = tisp_pkg::KIND_SDC;
        end else if (name_sr[31:8] == tisp_pkg::NAME_STR && name_sr[7:0] >= tisp_pkg::CHAR_0
                     && name_sr[7:0] <= tisp_pkg::CHAR_3) begin
            cur_kind = 3'(tisp_pkg::KIND_STR0) + 3'(name_sr[7:0] - tisp_pkg::CHAR_0);
        end else begin
            cur_kind  = tisp_pkg::KIND_DLFC;
            cur_known = 1'b0;
        end
    endtask

    task automatic parse_bit(input logic pbit, input logic start, input logic [18:0] total);
        logic last;
        if (start) begin
            bits_left = total;
            data_left = '0;
            cur_kind  = tisp_pkg::KIND_DLFC;
            cur_known = 1'b0;
            start_tag();
        end
        case (ph)
            tisp_pkg::PH_HEAD: begin
                if (hdr_cnt < 6'd32)
                    name_sr = {name_sr[30:0], pbit};
                else
                    len_sr = {len_sr[30:0], pbit};
                bits_left = bits_left - 1'b1;
                if (hdr_cnt != tisp_pkg::HDR_LAST) begin
                    hdr_cnt = hdr_cnt + 1'b1;
                end else begin
                    hdr_cnt = '0;
                    if (len_sr > 32'(bits_left)) begin
                        ph = tisp_pkg::PH_HALT;
                        push_expect(tisp_pkg::KIND_DLFC, 1'b0, 1'b0, 1'b0, 1'b1);
                    end else begin
                        classify_tag();
                        data_left = len_sr;
                        if (data_left == 0) begin
                            start_tag();
                            if (cur_known)
                                push_expect(cur_kind, 1'b0, 1'b1, 1'b1, 1'b0);
                        end else begin
                            ph = tisp_pkg::PH_DATA;
                        end
                    end
                end
            end
            tisp_pkg::PH_DATA: begin
                bits_left = bits_left - 1'b1;
                data_left = data_left - 1'b1;
                last = (data_left == 0);
                if (last)
                    start_tag();
                if (cur_known)
                    push_expect(cur_kind, pbit, last, 1'b0, 1'b0);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic bit roll_idle();
        if (cycle_cnt % 4000 >= 2800)
            return 1'b0;
        return ($urandom_range(0, 99) < 20);
    endfunction

    task automatic add_field(input logic [31:0] v, input int w);
        for (int i = w - 1; i >= 0; i--)
            frame_bits.insert(frame_bits.size(), v[i]);
    endtask

    task automatic add_tag(input logic [31:0] name, input logic [31:0] len, input int ndata);
        add_field(name, 32);
        add_field(len, 32);
        for (int i = 0; i < ndata; i++)
            frame_bits.insert(frame_bits.size(), 1'($urandom()));
    endtask

    task automatic add_filler(input int n);
        for (int i = 0; i < n; i++)
            frame_bits.insert(frame_bits.size(), 1'($urandom()));
    endtask

    task automatic send_frame(input logic [18:0] total);
        payload_xfer_t x;
        foreach (frame_bits[i]) begin
            x.pbit  = frame_bits[i];
            x.start = (i == 0);
            x.total = (i == 0) ? total : 19'($urandom());
            pending_bits.insert(pending_bits.size(), x);
        end
        frame_bits.delete();
    endtask

    task automatic send_noise(input int n);
        payload_xfer_t x;
        for (int i = 0; i < n; i++) begin
            x.pbit  = 1'($urandom());
            x.start = 1'b0;
            x.total = 19'($urandom());
            pending_bits.insert(pending_bits.size(), x);
        end
    endtask

    task automatic add_random_tag();
        int sel;
        int len;
        sel = $urandom_range(0, 11);
        len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
        case (sel)
            0: begin
                if ($urandom_range(0, 3) == 0)
                    add_tag(tisp_pkg::NAME_DLFC, len, len);
                else
                    add_tag(tisp_pkg::NAME_DLFC, tisp_pkg::DLFC_LEN, tisp_pkg::DLFC_LEN);
            end
            1: begin
                if ($urandom_range(0, 3) == 0)
                    add_tag(tisp_pkg::NAME_ROBM, len, len);
                else
                    add_tag(tisp_pkg::NAME_ROBM, tisp_pkg::ROBM_LEN, tisp_pkg::ROBM_LEN);
            end
            2: add_tag(tisp_pkg::NAME_FAC, len, len);
            3: add_tag(tisp_pkg::NAME_SDC, len, len);
            4, 5, 6, 7: add_tag({tisp_pkg::NAME_STR, tisp_pkg::CHAR_0 + 8'(sel - 4)}, len, len);
            8: add_tag($urandom(), len, len);
            9: add_tag({tisp_pkg::NAME_STR, ($urandom_range(0, 1) != 0) ? 8'h2F : 8'h34},
                       len, len);
            10: add_tag({tisp_pkg::NAME_STR, 8'($urandom())}, len, len);
            default: add_tag(tisp_pkg::NAME_FAC, $urandom() | 32'h0008_0000, 0);
        endcase
    endtask

    task automatic gen_frame();
        int n_tags;
        int size;
        int pick;
        logic [18:0] total;
        n_tags = $urandom_range(1, 4);
        for (int i = 0; i < n_tags; i++)
            add_random_tag();
        add_filler($urandom_range(0, 63));
        size = frame_bits.size();
        pick = $urandom_range(0, 9);
        if (pick == 0)
            total = 19'($urandom_range(0, size));
        else if (pick == 1)
            total = 19'(size + $urandom_range(64, 524287 - size));
        else
            total = 19'(size);
        send_frame(total);
        if ($urandom_range(0, 4) == 0)
            send_noise($urandom_range(1, 8));
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        err_cnt++;
    endtask

    // driver
    always @(posedge aclk) begin : drive
        payload_xfer_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                parse_bit(s_tdata[0], s_tuser, s_tdata[19:1]);
            if (!s_tvalid || s_tready) begin
                if (pending_bits.size() != 0 && !roll_idle()) begin
                    nxt = pending_bits.pop_front();
                    s_tdata  <= {4'b0, nxt.total, nxt.pbit};
                    s_tuser  <= nxt.start;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        tag_result_t want;
        m_tready <= aresetn && !roll_idle();
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tags.size() == 0) begin
                report_mismatch("unexpected result transfer", 0, 1);
            end else begin
                want = expected_tags.pop_front();
                if (m_tuser[2:0] !== want.kind)
                    report_mismatch("tag_kind", want.kind, m_tuser[2:0]);
                if (m_tdata[0] !== want.dbit)
                    report_mismatch("data_bit", want.dbit, m_tdata[0]);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_tag", want.last, m_tlast);
                if (m_tuser[3] !== want.empty)
                    report_mismatch("empty_tag", want.empty, m_tuser[3]);
                if (m_tuser[4] !== want.bad)
                    report_mismatch("malformed", want.bad, m_tuser[4]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // bits ahead of any start are ignored
        send_noise(3);

        // every known kind, exact total so the parser halts at the end
        add_tag(tisp_pkg::NAME_DLFC, tisp_pkg::DLFC_LEN, tisp_pkg::DLFC_LEN);
        add_tag(tisp_pkg::NAME_ROBM, tisp_pkg::ROBM_LEN, tisp_pkg::ROBM_LEN);
        add_tag(tisp_pkg::NAME_FAC, 5, 5);
        add_tag(tisp_pkg::NAME_SDC, 0, 0);
        for (int k = 0; k < 4; k++)
            add_tag({tisp_pkg::NAME_STR, tisp_pkg::CHAR_0 + 8'(k)}, k + 1, k + 1);
        send_frame(19'(frame_bits.size()));
        send_noise(4);

        // restrictive names and unknowns are skipped, then an empty known tag
        add_tag(tisp_pkg::NAME_DLFC, 7, 7);
        add_tag(tisp_pkg::NAME_ROBM, 9, 9);
        add_tag(32'h7879_7A31, 4, 4);
        add_tag({tisp_pkg::NAME_STR, 8'h34}, 2, 2);
        add_tag(tisp_pkg::NAME_FAC, 0, 0);
        add_filler(63);
        send_frame(19'(frame_bits.size()));

        // overlong tag halts the parser; the rest is ignored
        add_tag(tisp_pkg::NAME_FAC, 100, 50);
        send_frame(19'(64 + 50));
        send_noise(5);
        add_tag(tisp_pkg::NAME_SDC, 32'hFFFF_FFFF, 0);
        send_frame(19'h7FFFF);
        send_noise(2);

        // short payloads
        add_filler(63);
        send_frame(19'd63);
        add_filler(2);
        send_frame(19'd0);

        // restart in the middle of data
        add_tag(tisp_pkg::NAME_SDC, 20, 10);
        send_frame(19'(64 + 20));
        add_tag({tisp_pkg::NAME_STR, tisp_pkg::CHAR_3}, 4, 4);
        send_frame(19'h7FFFF);
        add_tag({tisp_pkg::NAME_STR, tisp_pkg::CHAR_0}, 3, 3);
        send_frame(19'(64 + 3));

        while (pending_bits.size() < ITEM_TARGET)
            gen_frame();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(posedge aclk);
        while (pending_bits.size() != 0 || s_tvalid || expected_tags.size() != 0);
        repeat (16) @(posedge aclk);

        if (expected_tags.size() != 0)
            report_mismatch("results left over", 0, expected_tags.size());

        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
